[hdl/raw_pixel_unpacker_defines.svh]
// Assertion macros for the raw pixel unpacker.
// Expects clk and arst_n in scope where the macros are used.
`ifndef RAW_PIXEL_UNPACKER_DEFINES_SVH
`define RAW_PIXEL_UNPACKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RPU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define RPU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/rpu_pkg.sv]
// Shared types, constants and color functions of the raw pixel unpacker.
// Used by every module of the block; depends on nothing.
package rpu_pkg;

	localparam int VISIBLE_COLUMNS = 150;
	localparam int MAX_ROWS        = 130;
	localparam int COL_W           = 16;
	localparam int ROW_W           = 8;
	localparam int JOB_FIFO_DEPTH  = 4;
	localparam int JOB_PTR_W       = $clog2(JOB_FIFO_DEPTH);

	localparam logic [COL_W-1:0] VISIBLE_COL_LIMIT = COL_W'(VISIBLE_COLUMNS);
	localparam logic [ROW_W-1:0] MAX_ROW_LIMIT     = ROW_W'(MAX_ROWS);

	localparam logic [3:0] MODE_GREY1   = 4'd0;
	localparam logic [3:0] MODE_GREY2   = 4'd1;
	localparam logic [3:0] MODE_GREY4   = 4'd2;
	localparam logic [3:0] MODE_GREY8   = 4'd3;
	localparam logic [3:0] MODE_RGB5551 = 4'd4;
	localparam logic [3:0] MODE_RGB4444 = 4'd5;
	localparam logic [3:0] MODE_RGB565  = 4'd6;
	localparam logic [3:0] MODE_BGR5551 = 4'd7;
	localparam logic [3:0] MODE_BGR4444 = 4'd8;
	localparam logic [3:0] MODE_BGR565  = 4'd9;
	localparam logic [3:0] MODE_RGB24   = 4'd10;
	localparam logic [3:0] MODE_BGR24   = 4'd11;

	localparam logic [1:0] CFG_PIXEL_MODE = 2'd0;
	localparam logic [1:0] CFG_ROW_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_ROW_COUNT  = 2'd2;

	localparam logic [3:0]  RESET_PIXEL_MODE = MODE_GREY8;
	localparam logic [15:0] RESET_ROW_WIDTH  = 16'd42;
	localparam logic [7:0]  RESET_ROW_COUNT  = 8'd100;

	localparam logic [23:0] GREY_ONE   = 24'h7F7F7F;
	localparam logic [23:0] GREY_LOW   = 24'h404040;
	localparam logic [23:0] GREY_MID   = 24'h808080;
	localparam logic [23:0] GREY_HIGH  = 24'hB0B0B0;

	typedef struct packed {
		logic [3:0]  pixel_mode;
		logic [15:0] row_width;
		logic [7:0]  row_count;
	} cfg_t;

	typedef enum logic [2:0] {
		JOB_NONE,
		JOB_SINGLE,
		JOB_PACK1,
		JOB_PACK2,
		JOB_PACK4
	} job_kind_t;

	typedef struct packed {
		logic        clear;
		job_kind_t   kind;
		logic [23:0] data;
	} job_t;

	typedef struct packed {
		logic [23:0]      color;
		logic [ROW_W-1:0] column;
		logic [ROW_W-1:0] row;
	} pixel_t;

	function automatic logic [23:0] swap_rb(input logic [23:0] c);
		return {c[7:0], c[15:8], c[23:16]};
	endfunction

	function automatic logic [23:0] color16(input logic [15:0] t, input logic [3:0] m);
		logic [23:0] c;
		case (m)
			MODE_RGB5551, MODE_BGR5551: c = {t[4:0], 3'b0, t[9:5], 3'b0, t[14:10], 3'b0};
			MODE_RGB4444, MODE_BGR4444: c = {t[11:8], 4'b0, t[7:4], 4'b0, t[3:0], 4'b0};
			default:                    c = {t[15:11], 3'b0, t[10:5], 2'b0, t[4:0], 3'b0};
		endcase
		return (m >= MODE_BGR5551) ? swap_rb(c) : c;
	endfunction

	function automatic logic [2:0] job_last_index(input job_kind_t kind);
		case (kind)
			JOB_PACK1: return 3'd7;
			JOB_PACK2: return 3'd3;
			JOB_PACK4: return 3'd1;
			default:   return 3'd0;
		endcase
	endfunction

endpackage

[hdl/rpu_byte_if.sv]
// Input channel of the raw pixel unpacker: one raw byte per beat.
// Depends on nothing but the handshake convention valid and ready.
interface rpu_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       frame_start;

	modport source(output valid, byte_value, frame_start, input ready);
	modport sink(input valid, byte_value, frame_start, output ready);
endinterface

[hdl/rpu_pixel_if.sv]
// Output channel of the raw pixel unpacker: one colored pixel per beat.
// Depends on nothing but the handshake convention valid and ready.
interface rpu_pixel_if;
	logic        valid;
	logic        ready;
	logic [23:0] pixel_color;
	logic [7:0]  column;
	logic [7:0]  row;
	logic        last_in_run;

	modport source(output valid, pixel_color, column, row, last_in_run, input ready);
	modport sink(input valid, pixel_color, column, row, last_in_run, output ready);
endinterface

[hdl/rpu_front.sv]
// Front end: accepts raw bytes, gathers multi-byte pixels, one job per grey byte or pixel.
// Depends on rpu_pkg and rpu_byte_if.
module rpu_front import rpu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	rpu_byte_if.sink    bytes,
	input  logic        job_full,
	output logic        job_push,
	output job_t        job
);

	logic [15:0] asm_q;
	logic [1:0]  phase_q;
	logic [15:0] asm_eff;
	logic [1:0]  phase_eff;
	logic [15:0] asm_n;
	logic [1:0]  phase_n;
	logic [7:0]  b;
	logic [3:0]  m;
	logic        accept;

	assign bytes.ready = !job_full;
	assign accept      = bytes.valid && bytes.ready;
	assign b           = bytes.byte_value;
	assign m           = cfg.pixel_mode;

	always_comb begin
		asm_eff   = bytes.frame_start ? 16'd0 : asm_q;
		phase_eff = bytes.frame_start ? 2'd0 : phase_q;
		asm_n     = asm_eff;
		phase_n   = phase_eff;
		job.clear = bytes.frame_start;
		job.kind  = JOB_NONE;
		job.data  = {16'd0, b};
		if (m inside {[MODE_GREY1:MODE_GREY4]}) begin
			phase_n = 2'd0;
			case (m)
				MODE_GREY1: job.kind = JOB_PACK1;
				MODE_GREY2: job.kind = JOB_PACK2;
				default:    job.kind = JOB_PACK4;
			endcase
		end else if (m == MODE_GREY8) begin
			phase_n  = 2'd0;
			job.kind = JOB_SINGLE;
			job.data = {b, b, b};
		end else if (m inside {[MODE_RGB5551:MODE_BGR565]}) begin
			if (phase_eff == 2'd0) begin
				asm_n   = {8'd0, b};
				phase_n = 2'd1;
			end else begin
				phase_n  = 2'd0;
				job.kind = JOB_SINGLE;
				job.data = color16({b, asm_eff[7:0]}, m);
			end
		end else if (m inside {MODE_RGB24, MODE_BGR24}) begin
			if (phase_eff == 2'd0) begin
				asm_n   = {8'd0, b};
				phase_n = 2'd1;
			end else if (phase_eff == 2'd1) begin
				asm_n   = {b, asm_eff[7:0]};
				phase_n = 2'd2;
			end else begin
				phase_n  = 2'd0;
				job.kind = JOB_SINGLE;
				job.data = (m == MODE_RGB24) ? {b, asm_eff} : swap_rb({b, asm_eff});
			end
		end
	end

	assign job_push = accept && (job.clear || (job.kind != JOB_NONE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asm_q   <= 16'd0;
			phase_q <= 2'd0;
		end else if (accept) begin
			asm_q   <= asm_n;
			phase_q <= phase_n;
		end
	end

endmodule

[hdl/rpu_job_fifo.sv]
// Short job queue between the front end and the pixel back end.
// Depends on rpu_pkg for the job type and the queue depth.
module rpu_job_fifo import rpu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output job_t head_job
);

	job_t                 mem [JOB_FIFO_DEPTH];
	logic [JOB_PTR_W-1:0] wr_ptr_q;
	logic [JOB_PTR_W-1:0] rd_ptr_q;
	logic [JOB_PTR_W:0]   count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full       = (count_q == (JOB_PTR_W+1)'(JOB_FIFO_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/rpu_back.sv]
// Back end: walks the pixels of each job, tracks column, row and frame end,
// and delivers visible pixels with the end-of-job flag. Depends on rpu_pkg and rpu_pixel_if.
module rpu_back import rpu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        head_valid,
	input  job_t        head_job,
	output logic        pop,
	rpu_pixel_if.source pixels
);

	logic [2:0]       k_q;
	logic             show_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             complete_q;

	logic             h_valid_q;
	logic             h_final_q;
	pixel_t           h_pix_q;

	logic             o_valid_q;
	logic             o_last_q;
	pixel_t           o_pix_q;

	logic             first;
	logic [COL_W-1:0] col_e;
	logic [ROW_W-1:0] row_e;
	logic             complete_e;
	logic [ROW_W-1:0] frame_h;
	logic             room;
	logic             visible;
	logic             show;
	logic [COL_W:0]   col_inc;
	logic             wrap;
	logic [COL_W-1:0] col_n;
	logic [ROW_W-1:0] row_n;
	logic             complete_n;
	logic [2:0]       shamt;
	logic [7:0]       shifted;
	logic [3:0]       v;
	logic [23:0]      color;
	logic             ev_pix;
	logic             ev_end;
	logic             out_want;
	logic             can_load;
	logic             fire;
	logic             step;
	pixel_t           cand;

	assign first      = (k_q == 3'd0);
	assign col_e      = (first && head_job.clear) ? '0 : col_q;
	assign row_e      = (first && head_job.clear) ? '0 : row_q;
	assign complete_e = (first && head_job.clear) ? 1'b0 : complete_q;
	assign frame_h    = (cfg.row_count > MAX_ROW_LIMIT) ? MAX_ROW_LIMIT : cfg.row_count;
	assign room       = !complete_e && (row_e < frame_h);
	assign visible    = (col_e < VISIBLE_COL_LIMIT);
	assign show       = first ? visible : show_q;
	assign col_inc    = {1'b0, col_e} + 1'b1;
	assign wrap       = (col_inc >= {1'b0, cfg.row_width});

	always_comb begin
		case (head_job.kind)
			JOB_PACK1: shamt = k_q;
			JOB_PACK2: shamt = {k_q[1:0], 1'b0};
			JOB_PACK4: shamt = {k_q[0], 2'b00};
			default:   shamt = 3'd0;
		endcase
		shifted = head_job.data[7:0] >> shamt;
		v       = shifted[3:0];
		case (head_job.kind)
			JOB_PACK1: color = v[0] ? GREY_ONE : 24'd0;
			JOB_PACK2: begin
				case (v[1:0])
					2'd0:    color = 24'd0;
					2'd1:    color = GREY_LOW;
					2'd2:    color = GREY_MID;
					default: color = GREY_HIGH;
				endcase
			end
			JOB_PACK4: color = {v, 4'h0, v, 4'h0, v, 4'h0};
			default:   color = head_job.data;
		endcase
	end

	always_comb begin
		col_n      = col_e;
		row_n      = row_e;
		complete_n = complete_e;
		ev_pix     = 1'b0;
		ev_end     = 1'b0;
		if (head_valid) begin
			if (head_job.kind == JOB_NONE) begin
				ev_end = 1'b1;
			end else if (!room) begin
				ev_end     = 1'b1;
				complete_n = 1'b1;
			end else begin
				ev_pix = show && visible;
				ev_end = (k_q == job_last_index(head_job.kind));
				col_n  = wrap ? '0 : col_inc[COL_W-1:0];
				row_n  = wrap ? row_e + 1'b1 : row_e;
			end
		end
	end

	assign cand.color  = color;
	assign cand.column = col_e[ROW_W-1:0];
	assign cand.row    = row_e;

	assign out_want = h_valid_q && (ev_pix || ev_end || h_final_q);
	assign can_load = !o_valid_q || pixels.ready;
	assign fire     = out_want && can_load;
	assign step     = head_valid && !(out_want && !can_load);
	assign pop      = step && ev_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q        <= 3'd0;
			show_q     <= 1'b0;
			col_q      <= '0;
			row_q      <= '0;
			complete_q <= 1'b0;
		end else if (step) begin
			k_q        <= ev_end ? 3'd0 : k_q + 1'b1;
			show_q     <= show;
			col_q      <= col_n;
			row_q      <= row_n;
			complete_q <= complete_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_valid_q <= 1'b0;
			h_final_q <= 1'b0;
		end else if (step && ev_pix) begin
			h_valid_q <= 1'b1;
			h_final_q <= ev_end;
		end else if (fire) begin
			h_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && ev_pix) begin
			h_pix_q <= cand;
		end
		if (fire) begin
			o_pix_q  <= h_pix_q;
			o_last_q <= h_final_q || (ev_end && !ev_pix);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (fire) begin
			o_valid_q <= 1'b1;
		end else if (pixels.ready) begin
			o_valid_q <= 1'b0;
		end
	end

	assign pixels.valid       = o_valid_q;
	assign pixels.pixel_color = o_pix_q.color;
	assign pixels.column      = o_pix_q.column;
	assign pixels.row         = o_pix_q.row;
	assign pixels.last_in_run = o_last_q;

endmodule

[hdl/raw_pixel_unpacker.sv]
// Raw pixel unpacker: raw bytes in, one 24-bit pixel per beat out.
// Path: an accepted byte's job enters the job queue; the back end loads each shown pixel into a
// holding register, then the output register; a packed pixel waits for the next shown pixel
// or its byte end. Throughput: one pixel per cycle while jobs wait and the output is not stalled;
// a 1-bit byte holds 8 pixels, 2-bit 4, 4-bit 2, 8-bit 1; a four-job queue takes new bytes meanwhile.
// Reset clears the byte assembly, counters and job queue and loads mode 3, width 42, 100 rows.
`include "raw_pixel_unpacker_defines.svh"
module raw_pixel_unpacker import rpu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	rpu_byte_if.sink    bytes,
	rpu_pixel_if.source pixels
);

	cfg_t cfg_q;
	logic job_push;
	job_t job;
	logic job_full;
	logic job_pop;
	logic head_valid;
	job_t head_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_mode <= RESET_PIXEL_MODE;
			cfg_q.row_width  <= RESET_ROW_WIDTH;
			cfg_q.row_count  <= RESET_ROW_COUNT;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_PIXEL_MODE: cfg_q.pixel_mode <= cfg_data[3:0];
				CFG_ROW_WIDTH:  cfg_q.row_width  <= cfg_data;
				CFG_ROW_COUNT:  cfg_q.row_count  <= cfg_data[7:0];
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	rpu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.bytes    (bytes),
		.job_full (job_full),
		.job_push (job_push),
		.job      (job)
	);

	rpu_job_fifo u_job_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_push),
		.push_job   (job),
		.full       (job_full),
		.pop        (job_pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	rpu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (job_pop),
		.pixels     (pixels)
	);

	`RPU_ASSERT_IMP(a_no_push_when_full, job_push, !job_full, "job pushed into a full queue")
	`RPU_ASSERT_IMP(a_pop_needs_job, job_pop, head_valid, "job popped from an empty queue")
	`RPU_ASSERT_NXT(a_push_fills_head, job_push && !head_valid, head_valid, "pushed job not at head")
	`RPU_ASSERT_IMP(a_row_in_frame, pixels.valid, int'(pixels.row) < MAX_ROWS, "pixel row beyond frame")

endmodule
